[design/fdd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fdd_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int DIGIT_W     = 4;
    localparam int CFG_IDX_W   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_MATCH_ADDRESS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_MASK     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_MODE  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_OFFSET  = 4'd3;

    localparam logic [1:0] MODE_FOUR   = 2'd0;
    localparam logic [1:0] MODE_SPLIT  = 2'd1;
    localparam logic [1:0] MODE_SINGLE = 2'd2;

    localparam logic [15:0] MASK_HIGH_BYTE = 16'hFF00;

    // Digit zero is the leftmost (thousands) digit.
    typedef logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] t_digits;

    // Partial decimal split of one frame, handed to the digit store.
    typedef struct packed {
        logic [6:0] thou_q;   // masked word / 1000, 0..65
        logic [3:0] hund;     // hundreds digit of masked word
        logic [3:0] tens;     // tens digit of masked word
        logic [3:0] units;    // units digit of masked word
        logic [4:0] byte_tq;  // selected byte / 10, 0..25
        logic [3:0] byte_u;   // units digit of selected byte
    } t_conv;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] offset;
    } t_disp_cfg;

    // x / 100 for any 16-bit x: divide by 4, then by 25 through a reciprocal.
    function automatic logic [9:0] div100(input logic [15:0] x);
        logic [27:0] p;
        p = 28'(x[15:2]) * 28'd5243;
        return p[26:17];
    endfunction

    // x / 10 for x below 1029.
    function automatic logic [6:0] div10(input logic [9:0] x);
        logic [21:0] p;
        p = 22'(x) * 22'd205;
        return p[17:11];
    endfunction

endpackage

`default_nettype wire

[design/fdd_store.sv]
`timescale 1ns / 1ps
`default_nettype none

module fdd_store (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire fdd_pkg::t_conv    i_conv,
    input  wire fdd_pkg::t_disp_cfg i_cfg,
    output fdd_pkg::t_digits       o_digits
);

    fdd_pkg::t_digits r_digit;
    fdd_pkg::t_digits n_digit;

    logic [6:0] thou_div;
    logic [6:0] byte_div;
    logic [3:0] thou_digit;
    logic [3:0] byte_tens;
    logic [2:0] units_pos;

    always_comb begin
        thou_div   = fdd_pkg::div10(10'(i_conv.thou_q));
        byte_div   = fdd_pkg::div10(10'(i_conv.byte_tq));
        thou_digit = 4'(i_conv.thou_q - 7'(thou_div * 7'd10));
        // hundreds of the byte drop out here
        byte_tens  = 4'(7'(i_conv.byte_tq) - 7'(byte_div * 7'd10));
        units_pos  = {1'b0, i_cfg.offset} + 3'd1;
    end

    always_comb begin
        n_digit = r_digit;
        case (i_cfg.mode)
            fdd_pkg::MODE_FOUR: begin
                n_digit[0] = thou_digit;
                n_digit[1] = i_conv.hund;
                n_digit[2] = i_conv.tens;
                n_digit[3] = i_conv.units;
            end
            fdd_pkg::MODE_SPLIT: begin
                // units past the last digit fall off
                for (int i = 0; i < fdd_pkg::DIGIT_COUNT; i++) begin
                    if (2'(i) == i_cfg.offset) begin
                        n_digit[i] = byte_tens;
                    end else if (3'(i) == units_pos) begin
                        n_digit[i] = i_conv.byte_u;
                    end
                end
            end
            fdd_pkg::MODE_SINGLE: begin
                for (int i = 0; i < fdd_pkg::DIGIT_COUNT; i++) begin
                    if (2'(i) == i_cfg.offset) begin
                        n_digit[i] = i_conv.byte_u;
                    end
                end
            end
            default: begin
                n_digit = r_digit;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit <= '0;
        end else if (i_load) begin
            r_digit <= n_digit;
        end
    end

    assign o_digits = r_digit;

endmodule

`default_nettype wire

[design/frame_to_decimal_digit_display_top.sv]
// Channel  | Handshake               | Payload
// ---------+-------------------------+-----------------------------------------
// frame in | i_valid / o_stall       | i_frame_address, i_data_word, i_byte_count
// digits   | o_valid / i_stall       | o_digit_zero .. o_digit_three
// config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// While o_stall is low, one frame per cycle is taken; a matching frame shows its digits
// after it passes the input register, two conversion stages and the digit store.
// Frames that are short or carry another address are dropped after the input
// register and produce no request on the output.
// The digit store is the output register; reset clears it and returns the config to its defaults.
// i_stall holds the output; bubbles between stages still fill behind it.
`timescale 1ns / 1ps
`default_nettype none

module frame_to_decimal_digit_display_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [15:0]                     i_frame_address,
    input  wire logic [15:0]                     i_data_word,
    input  wire logic [15:0]                     i_byte_count,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [3:0]                           o_digit_zero,
    output logic [3:0]                           o_digit_one,
    output logic [3:0]                           o_digit_two,
    output logic [3:0]                           o_digit_three,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [fdd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [15:0]                     i_cfg_data
);

    // configuration
    logic [15:0] r_match;
    logic [15:0] r_mask;
    logic [1:0]  r_mode;
    logic [1:0]  r_offset;

    // pipeline valids
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_vo;

    // stage 1: raw frame
    logic [15:0] r1_addr;
    logic [15:0] r1_word;
    logic [15:0] r1_count;

    // stage 2: word split by 100, selected byte
    logic [9:0]  r2_q;
    logic [6:0]  r2_r;
    logic [7:0]  r2_byte;

    // stage 3
    fdd_pkg::t_conv r3_conv;

    logic        accept;
    logic        hit1;
    logic        move1;
    logic        move2;
    logic        move3;
    logic        take_o;
    logic [15:0] masked;
    logic [9:0]  q100;
    logic [15:0] q100_x100;
    logic [6:0]  q_div;
    logic [6:0]  r_div;
    logic [6:0]  b_div;
    fdd_pkg::t_conv    conv3;
    fdd_pkg::t_disp_cfg disp_cfg;
    fdd_pkg::t_digits  digits;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match  <= '0;
            r_mask   <= 16'hFFFF;
            r_mode   <= fdd_pkg::MODE_FOUR;
            r_offset <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                fdd_pkg::REG_MATCH_ADDRESS: r_match  <= i_cfg_data;
                fdd_pkg::REG_DATA_MASK:     r_mask   <= i_cfg_data;
                fdd_pkg::REG_DISPLAY_MODE:  r_mode   <= i_cfg_data[1:0];
                fdd_pkg::REG_DIGIT_OFFSET:  r_offset <= i_cfg_data[1:0];
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    // handshake: a stage moves on when the next one is empty or moving; stage 1 also moves when its frame is dropped
    always_comb begin
        take_o  = r_vo && !i_stall;
        move3   = r_v3 && (!r_vo || !i_stall);
        move2   = r_v2 && (!r_v3 || move3);
        hit1    = (|r1_count[15:1]) && (r1_addr == r_match);
        move1   = r_v1 && (!hit1 || !r_v2 || move2);
        o_stall = r_v1 && !move1;
        accept  = i_valid && !o_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (accept) begin
                r_v1 <= 1'b1;
            end else if (move1) begin
                r_v1 <= 1'b0;
            end
            if (move1 && hit1) begin
                r_v2 <= 1'b1;
            end else if (move2) begin
                r_v2 <= 1'b0;
            end
            if (move2) begin
                r_v3 <= 1'b1;
            end else if (move3) begin
                r_v3 <= 1'b0;
            end
            if (move3) begin
                r_vo <= 1'b1;
            end else if (take_o) begin
                r_vo <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_addr  <= i_frame_address;
            r1_word  <= i_data_word;
            r1_count <= i_byte_count;
        end
    end

    always_comb begin
        masked    = r1_word & r_mask;
        q100      = fdd_pkg::div100(masked);
        q100_x100 = {q100, 6'b0} + {1'b0, q100, 5'b0} + {4'b0, q100, 2'b0};
    end

    always_ff @(posedge i_clk) begin
        if (move1 && hit1) begin
            r2_q <= q100;
            r2_r <= 7'(masked - q100_x100);
            if ((r_mask & fdd_pkg::MASK_HIGH_BYTE) != 16'd0) begin
                r2_byte <= masked[15:8];
            end else begin
                r2_byte <= masked[7:0];
            end
        end
    end

    always_comb begin
        q_div         = fdd_pkg::div10(r2_q);
        r_div         = fdd_pkg::div10(10'(r2_r));
        b_div         = fdd_pkg::div10(10'(r2_byte));
        conv3.thou_q  = q_div;
        conv3.hund    = 4'(r2_q - 10'(q_div) * 10'd10);
        conv3.tens    = 4'(r_div);
        conv3.units   = 4'(r2_r - 7'(r_div * 7'd10));
        conv3.byte_tq = 5'(b_div);
        conv3.byte_u  = 4'(r2_byte - 8'(b_div) * 8'd10);
    end

    always_ff @(posedge i_clk) begin
        if (move2) begin
            r3_conv <= conv3;
        end
    end

    assign disp_cfg.mode   = r_mode;
    assign disp_cfg.offset = r_offset;

    fdd_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (move3),
        .i_conv   (r3_conv),
        .i_cfg    (disp_cfg),
        .o_digits (digits)
    );

    assign o_valid       = r_vo;
    assign o_digit_zero  = digits[0];
    assign o_digit_one   = digits[1];
    assign o_digit_two   = digits[2];
    assign o_digit_three = digits[3];

endmodule

`default_nettype wire

[design/fdd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module fdd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [3:0] o_digit_zero,
    input wire logic [3:0] o_digit_one,
    input wire logic [3:0] o_digit_two,
    input wire logic [3:0] o_digit_three
);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_digits_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit_zero <= 4'd9) && (o_digit_one <= 4'd9)
                 && (o_digit_two <= 4'd9) && (o_digit_three <= 4'd9))
        else $error("digit out of decimal range");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_digit_zero)
            && $stable(o_digit_one) && $stable(o_digit_two) && $stable(o_digit_three))
        else $error("stalled request changed");

    // the store only changes when a new request is presented
    a_store_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !o_valid |-> $stable(o_digit_zero) && $stable(o_digit_one)
            && $stable(o_digit_two) && $stable(o_digit_three))
        else $error("digits changed without a request");

endmodule

bind frame_to_decimal_digit_display_top fdd_checker u_fdd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_digit_zero  (o_digit_zero),
    .o_digit_one   (o_digit_one),
    .o_digit_two   (o_digit_two),
    .o_digit_three (o_digit_three)
);

`default_nettype wire
